[hw/rtl/mahd_pkg.sv]
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared codes, widths and pipeline types of the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

  // header field codes
  localparam logic [1:0] VER_2_5    = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_2      = 2'd2;
  localparam logic [1:0] VER_1      = 2'd3;
  localparam logic [1:0] LAYER_RSVD = 2'd0;
  localparam logic [1:0] LAYER_1    = 2'd3;
  localparam logic [3:0] RATE_FREE  = 4'd0;
  localparam logic [3:0] RATE_BAD   = 4'd15;
  localparam logic [1:0] FREQ_RSVD  = 2'd3;

  // divider chain: one quotient bit per cell
  localparam int DIV_W     = 32;
  localparam int REM_W     = 16;
  localparam int DIV_STEPS = DIV_W;

  // one header request
  typedef struct packed {
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [3:0]  rate_index;
    logic [1:0]  freq_index;
    logic        pad_slot;
    logic [31:0] file_bytes;
  } hdr_t;

  // one result request
  typedef struct packed {
    logic [18:0] bit_rate_bps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [22:0] duration_s;
    logic        header_ok;
  } res_t;

  // word handed from cell to cell: two divisions run side by side
  typedef struct packed {
    logic [DIV_W-1:0] fw;    // frame dividend, shifts out, quotient shifts in
    logic [REM_W-1:0] fr;    // frame partial remainder
    logic [REM_W-1:0] fd;    // frame divisor (sample rate)
    logic [DIV_W-1:0] dw;    // duration dividend / quotient
    logic [REM_W-1:0] dr;    // duration partial remainder
    logic [REM_W-1:0] dd;    // duration divisor (bytes per second)
    logic [18:0]      rate;
    logic [15:0]      freq;
    logic             ok;
    logic             lay1;
    logic             pad;
  } pipe_t;

endpackage

[hw/rtl/mahd_if.sv]
// ----------------------------------------------------------------------------
// mahd_if
// Valid/ready channels for header requests and result requests.
// ----------------------------------------------------------------------------
interface mahd_hdr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  version_code;
  logic [1:0]  layer_code;
  logic [3:0]  rate_index;
  logic [1:0]  freq_index;
  logic        pad_slot;
  logic [31:0] file_bytes;

  modport source (output valid, version_code, layer_code, rate_index, freq_index,
                  pad_slot, file_bytes, input ready);
  modport sink   (input valid, version_code, layer_code, rate_index, freq_index,
                  pad_slot, file_bytes, output ready);
endinterface

interface mahd_res_if;
  logic        valid;
  logic        ready;
  logic [18:0] bit_rate_bps;
  logic [15:0] sample_rate_hz;
  logic [11:0] frame_bytes;
  logic [22:0] duration_s;
  logic        header_ok;

  modport source (output valid, bit_rate_bps, sample_rate_hz, frame_bytes,
                  duration_s, header_ok, input ready);
  modport sink   (input valid, bit_rate_bps, sample_rate_hz, frame_bytes,
                  duration_s, header_ok, output ready);
endinterface

[hw/rtl/mahd_front.sv]
// ----------------------------------------------------------------------------
// mahd_front
// Checks header codes, looks up bit and sample rates, loads the divider chain.
// ----------------------------------------------------------------------------
module mahd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            a_valid,
  input  mahd_pkg::hdr_t  a,
  output logic            y_valid,
  output mahd_pkg::pipe_t y
);
  import mahd_pkg::*;

  // kbit/s, rows: v1 L1, v1 L2, v1 L3, v2 L1, v2 L2, v2 L3
  localparam logic [8:0] KBPS_TAB [0:5][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // Hz, columns: v1, v2, v2.5
  localparam logic [15:0] HZ_TAB [0:3][0:2] = '{
    '{16'd44100, 16'd22050, 16'd11025},
    '{16'd48000, 16'd24000, 16'd12000},
    '{16'd32000, 16'd16000, 16'd8000},
    '{16'd0,     16'd0,     16'd0}
  };

  logic        ok;
  logic        is_v1;
  logic [1:0]  col;
  logic [2:0]  row;
  logic [1:0]  fcol;
  logic [8:0]  kbps;
  logic [15:0] hz;
  logic [25:0] fdiv;
  pipe_t       nxt;

  // code checks and table lookups
  always_comb begin
    ok    = (a.version_code != VER_RSVD) && (a.layer_code != LAYER_RSVD) &&
            (a.rate_index != RATE_FREE) && (a.rate_index != RATE_BAD) &&
            (a.freq_index != FREQ_RSVD);
    is_v1 = (a.version_code == VER_1);
    col   = (a.layer_code == LAYER_RSVD) ? 2'd0 : 2'(LAYER_1 - a.layer_code);
    row   = is_v1 ? 3'(col) : 3'(3'd3 + 3'(col));
    case (a.version_code)
      VER_1:   fcol = 2'd0;
      VER_2:   fcol = 2'd1;
      default: fcol = 2'd2;
    endcase
    kbps  = KBPS_TAB[row][a.rate_index];
    hz    = HZ_TAB[a.freq_index][fcol];
    // 12*rate for layer I, 144*rate otherwise; rate = kbps*1000
    fdiv  = (a.layer_code == LAYER_1) ? 26'(32'(kbps) * 32'd12000)
                                      : 26'(32'(kbps) * 32'd144000);

    nxt      = '0;
    nxt.fw   = DIV_W'(fdiv);
    nxt.fd   = hz;
    nxt.dw   = a.file_bytes;
    nxt.dd   = REM_W'(32'(kbps) * 32'd125);   // rate/8 in bytes per second
    nxt.rate = ok ? 19'(32'(kbps) * 32'd1000) : 19'd0;
    nxt.freq = ok ? hz : 16'd0;
    nxt.ok   = ok;
    nxt.lay1 = (a.layer_code == LAYER_1);
    nxt.pad  = a.pad_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (en) begin
      y_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= nxt;
    end
  end

endmodule

[hw/rtl/mahd_cell.sv]
// ----------------------------------------------------------------------------
// mahd_cell
// One restoring-division step for both the frame and the duration quotient.
// ----------------------------------------------------------------------------
module mahd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            a_valid,
  input  mahd_pkg::pipe_t a,
  output logic            y_valid,
  output mahd_pkg::pipe_t y
);
  import mahd_pkg::*;

  logic [REM_W:0]   trial_f;
  logic [REM_W:0]   trial_d;
  logic [REM_W+1:0] sub_f;
  logic [REM_W+1:0] sub_d;
  pipe_t            nxt;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial_f = {a.fr, a.fw[DIV_W-1]};
    trial_d = {a.dr, a.dw[DIV_W-1]};
    sub_f   = {1'b0, trial_f} - {2'b00, a.fd};
    sub_d   = {1'b0, trial_d} - {2'b00, a.dd};
    nxt     = a;
    nxt.fw  = {a.fw[DIV_W-2:0], ~sub_f[REM_W+1]};
    nxt.dw  = {a.dw[DIV_W-2:0], ~sub_d[REM_W+1]};
    nxt.fr  = sub_f[REM_W+1] ? trial_f[REM_W-1:0] : sub_f[REM_W-1:0];
    nxt.dr  = sub_d[REM_W+1] ? trial_d[REM_W-1:0] : sub_d[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (en) begin
      y_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= nxt;
    end
  end

endmodule

[hw/rtl/mahd_out.sv]
// ----------------------------------------------------------------------------
// mahd_out
// Formats the quotients and holds results in an output register plus skid.
// ----------------------------------------------------------------------------
module mahd_out (
  input  logic            clk,
  input  logic            rst,
  output logic            en,
  input  logic            a_valid,
  input  mahd_pkg::pipe_t a,
  output logic            res_valid,
  input  logic            res_ready,
  output mahd_pkg::res_t  res
);
  import mahd_pkg::*;

  logic        skid_valid;
  res_t        skid;
  res_t        fmt;
  logic [12:0] frame_sum;
  logic        take;

  // frame = q + pad, times four for layer I; zero derived values if invalid
  always_comb begin
    frame_sum          = 13'(a.fw[11:0]) + 13'(a.pad);
    fmt.bit_rate_bps   = a.rate;
    fmt.sample_rate_hz = a.freq;
    fmt.frame_bytes    = !a.ok ? 12'd0 :
                         a.lay1 ? {frame_sum[9:0], 2'b00} : frame_sum[11:0];
    fmt.duration_s     = a.ok ? a.dw[22:0] : 23'd0;
    fmt.header_ok      = a.ok;
  end

  assign en   = ~skid_valid;
  assign take = res_valid & res_ready;

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (a_valid) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        res <= skid;
      end
    end else if (a_valid) begin
      if (!res_valid || take) begin
        res <= fmt;
      end else begin
        skid <= fmt;
      end
    end
  end

endmodule

[hw/rtl/mpeg_audio_header_decode.sv]
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode
// MPEG audio frame header decode: rates, frame length and file duration.
// ----------------------------------------------------------------------------
// Channel  Dir  Modport  Carries
// hdr      in   sink     version, layer, rate/freq index, padding, file size
// res      out  source   bit rate, sample rate, frame bytes, duration, ok
//
// One header per cycle is taken while hdr.ready is high; a result passes
// through the lookup stage, 32 divider cells and the output register.
// The 32-cell restoring divider chain sets the latency: one quotient bit per
// cell, both divisions run side by side in each cell.
// Reset (rst, synchronous) clears all valid bits; no clearing pass.
// A stalled result is held in the output register; one more lands in a skid
// register, and only then does hdr.ready drop and the chain stop.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decode (
  input  logic       clk,
  input  logic       rst,
  mahd_hdr_if.sink   hdr,
  mahd_res_if.source res
);
  import mahd_pkg::*;

  logic  en;
  logic  front_valid;
  pipe_t front;
  hdr_t  hdr_word;
  res_t  res_word;
  logic  cv [0:DIV_STEPS];
  pipe_t cp [0:DIV_STEPS];

  assign hdr_word.version_code = hdr.version_code;
  assign hdr_word.layer_code   = hdr.layer_code;
  assign hdr_word.rate_index   = hdr.rate_index;
  assign hdr_word.freq_index   = hdr.freq_index;
  assign hdr_word.pad_slot     = hdr.pad_slot;
  assign hdr_word.file_bytes   = hdr.file_bytes;
  assign hdr.ready             = en;

  mahd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (hdr.valid),
    .a       (hdr_word),
    .y_valid (front_valid),
    .y       (front)
  );

  assign cv[0] = front_valid;
  assign cp[0] = front;

  // divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    mahd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .a_valid (cv[i]),
      .a       (cp[i]),
      .y_valid (cv[i+1]),
      .y       (cp[i+1])
    );
  end

  mahd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .a_valid   (cv[DIV_STEPS]),
    .a         (cp[DIV_STEPS]),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res_word)
  );

  assign res.bit_rate_bps   = res_word.bit_rate_bps;
  assign res.sample_rate_hz = res_word.sample_rate_hz;
  assign res.frame_bytes    = res_word.frame_bytes;
  assign res.duration_s     = res_word.duration_s;
  assign res.header_ok      = res_word.header_ok;

endmodule

[hw/rtl/mahd_checker.sv]
// ----------------------------------------------------------------------------
// mahd_checker
// Port-level assertions for the header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mahd_checker (
  input logic        clk,
  input logic        rst,
  input logic        hdr_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [18:0] bit_rate_bps,
  input logic [15:0] sample_rate_hz,
  input logic [11:0] frame_bytes,
  input logic [22:0] duration_s,
  input logic        header_ok
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(bit_rate_bps) &&
      $stable(sample_rate_hz) && $stable(frame_bytes) &&
      $stable(duration_s) && $stable(header_ok))
    else $error("result changed while stalled");

  // input only backs up once a result is waiting
  a_ready_skid: assert property (@(posedge clk) disable iff (rst)
    !hdr_ready |-> res_valid)
    else $error("header refused with empty output");

  // bad header gives all-zero derived values
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !header_ok |-> bit_rate_bps == 19'd0 &&
      sample_rate_hz == 16'd0 && frame_bytes == 12'd0 && duration_s == 23'd0)
    else $error("invalid header with nonzero outputs");

  // good header gives nonzero rates and frame
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && header_ok |-> bit_rate_bps != 19'd0 &&
      sample_rate_hz != 16'd0 && frame_bytes != 12'd0)
    else $error("valid header with zero rate or frame");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind mpeg_audio_header_decode mahd_checker u_mahd_checker (
  .clk            (clk),
  .rst            (rst),
  .hdr_ready      (hdr.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .bit_rate_bps   (res.bit_rate_bps),
  .sample_rate_hz (res.sample_rate_hz),
  .frame_bytes    (res.frame_bytes),
  .duration_s     (res.duration_s),
  .header_ok      (res.header_ok)
);

[tb/tb_mpeg_audio_header_decode.sv]
// ----------------------------------------------------------------------------
// tb_mpeg_audio_header_decode
// Self-checking bench for the MPEG audio header decoder. Header requests are
// driven on the hdr channel and every accepted one is decoded by a local
// model (bit rate, sample rate, frame length, duration, header_ok). Result
// requests are matched in order against those predictions. Phases cover
// directed corner headers, then random traffic with no idling, sender gaps,
// a pause until the pipe drains, receiver stalls, and both at once.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_header_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import mahd_pkg::*;

  // layer and sample-rate codes not named in the package
  localparam logic [1:0] LAYER_2  = 2'd2;
  localparam logic [1:0] LAYER_3  = 2'd1;
  localparam logic [1:0] FREQ_44K = 2'd0;
  localparam logic [1:0] FREQ_48K = 2'd1;
  localparam logic [1:0] FREQ_32K = 2'd2;

  localparam int PIPE_LATENCY   = 34;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 200;

  logic clk = 1'b0;
  logic rst;

  mahd_hdr_if hdr_ch ();
  mahd_res_if res_ch ();

  mpeg_audio_header_decode u_top (
    .clk (clk),
    .rst (rst),
    .hdr (hdr_ch),
    .res (res_ch)
  );

  always #2 clk = ~clk;

  res_t pending_decodes[$];
  int   mismatch_count  = 0;
  int   idle_cycles     = 0;
  int   send_idle_pct   = 0;
  int   ready_stall_pct = 0;

  // bit rate in kbit/s; v1 picks by layer, v2/v2.5 share a row for L1 and one for L2/L3
  function automatic int unsigned kbps_lookup(logic [3:0] ri, bit is_v1, logic [1:0] lay);
    logic [4:0][8:0] row;  // [4] v1 L1, [3] v1 L2, [2] v1 L3, [1] v2 L1, [0] v2 L2/L3
    case (ri)
      4'd1:    row = {9'd32,  9'd32,  9'd32,  9'd32,  9'd8};
      4'd2:    row = {9'd64,  9'd48,  9'd40,  9'd48,  9'd16};
      4'd3:    row = {9'd96,  9'd56,  9'd48,  9'd56,  9'd24};
      4'd4:    row = {9'd128, 9'd64,  9'd56,  9'd64,  9'd32};
      4'd5:    row = {9'd160, 9'd80,  9'd64,  9'd80,  9'd40};
      4'd6:    row = {9'd192, 9'd96,  9'd80,  9'd96,  9'd48};
      4'd7:    row = {9'd224, 9'd112, 9'd96,  9'd112, 9'd56};
      4'd8:    row = {9'd256, 9'd128, 9'd112, 9'd128, 9'd64};
      4'd9:    row = {9'd288, 9'd160, 9'd128, 9'd144, 9'd80};
      4'd10:   row = {9'd320, 9'd192, 9'd160, 9'd160, 9'd96};
      4'd11:   row = {9'd352, 9'd224, 9'd192, 9'd176, 9'd112};
      4'd12:   row = {9'd384, 9'd256, 9'd224, 9'd192, 9'd128};
      4'd13:   row = {9'd416, 9'd320, 9'd256, 9'd224, 9'd144};
      4'd14:   row = {9'd448, 9'd384, 9'd320, 9'd256, 9'd160};
      default: row = '0;
    endcase
    if (is_v1) begin
      case (lay)
        LAYER_1: return row[4];
        LAYER_2: return row[3];
        default: return row[2];
      endcase
    end
    return (lay == LAYER_1) ? row[1] : row[0];
  endfunction

  // sample rate in Hz per version
  function automatic int unsigned hz_lookup(logic [1:0] fi, logic [1:0] ver);
    logic [2:0][15:0] row;  // [2] v1, [1] v2, [0] v2.5
    case (fi)
      FREQ_44K: row = {16'd44100, 16'd22050, 16'd11025};
      FREQ_48K: row = {16'd48000, 16'd24000, 16'd12000};
      FREQ_32K: row = {16'd32000, 16'd16000, 16'd8000};
      default:  row = '0;
    endcase
    case (ver)
      VER_1:   return row[2];
      VER_2:   return row[1];
      default: return row[0];
    endcase
  endfunction

  // full decode of one header request
  function automatic res_t decode_header(hdr_t h);
    res_t              r;
    bit                ok;
    longint unsigned   rate;
    longint unsigned   freq;
    longint unsigned   frame;
    longint unsigned   dur;
    r    = '0;
    ok   = (h.version_code != VER_RSVD) && (h.layer_code != LAYER_RSVD) &&
           (h.rate_index != RATE_FREE) && (h.rate_index != RATE_BAD) &&
           (h.freq_index != FREQ_RSVD);
    if (ok) begin
      rate = longint'(kbps_lookup(h.rate_index, h.version_code == VER_1, h.layer_code)) * 1000;
      freq = longint'(hz_lookup(h.freq_index, h.version_code));
      if (h.layer_code == LAYER_1)
        frame = 4 * ((12 * rate) / freq + h.pad_slot);
      else
        frame = (144 * rate) / freq + h.pad_slot;
      dur = longint'(h.file_bytes) / (rate / 8);
      r.bit_rate_bps   = rate[18:0];
      r.sample_rate_hz = freq[15:0];
      r.frame_bytes    = frame[11:0];
      r.duration_s     = dur[22:0];
      r.header_ok      = 1'b1;
    end
    return r;
  endfunction

  function automatic hdr_t random_header();
    hdr_t h;
    int   pick;
    h = '0;
    if ($urandom_range(99) < 80) begin
      // well-formed header
      pick = $urandom_range(2);
      h.version_code = (pick == 0) ? VER_2_5 : (pick == 1) ? VER_2 : VER_1;
      h.layer_code   = 2'($urandom_range(1, 3));
      h.rate_index   = 4'($urandom_range(1, 14));
      h.freq_index   = 2'($urandom_range(0, 2));
    end else begin
      h.version_code = 2'($urandom);
      h.layer_code   = 2'($urandom);
      h.rate_index   = 4'($urandom);
      h.freq_index   = 2'($urandom);
    end
    h.pad_slot = 1'($urandom);
    pick = $urandom_range(7);
    if (pick < 2)
      h.file_bytes = $urandom_range(0, 100000);
    else if (pick == 2)
      h.file_bytes = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    else
      h.file_bytes = $urandom;
    return h;
  endfunction

  // one header request; called and returns at a falling edge, valid left high
  task automatic send_header(input hdr_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      hdr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hdr_ch.valid        <= 1'b1;
    hdr_ch.version_code <= h.version_code;
    hdr_ch.layer_code   <= h.layer_code;
    hdr_ch.rate_index   <= h.rate_index;
    hdr_ch.freq_index   <= h.freq_index;
    hdr_ch.pad_slot     <= h.pad_slot;
    hdr_ch.file_bytes   <= h.file_bytes;
    @(posedge clk);
    while (!hdr_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and hold off until every decode has come back
  task automatic wait_drained();
    hdr_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_decodes.size() != 0);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_header(random_header());
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // predict on accepted headers, check accepted results, watchdog
  always @(posedge clk) begin
    res_t exp_r;
    res_t got_r;
    if (!rst) begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        pending_decodes.push_back(decode_header(hdr_t'{hdr_ch.version_code,
          hdr_ch.layer_code, hdr_ch.rate_index, hdr_ch.freq_index,
          hdr_ch.pad_slot, hdr_ch.file_bytes}));
      end
      if (res_ch.valid && res_ch.ready) begin
        got_r = res_t'{res_ch.bit_rate_bps, res_ch.sample_rate_hz, res_ch.frame_bytes,
                       res_ch.duration_s, res_ch.header_ok};
        if (pending_decodes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %h", $time, got_r);
        end else begin
          exp_r = pending_decodes.pop_front();
          check_field("bit_rate_bps",   exp_r.bit_rate_bps,   got_r.bit_rate_bps);
          check_field("sample_rate_hz", exp_r.sample_rate_hz, got_r.sample_rate_hz);
          check_field("frame_bytes",    exp_r.frame_bytes,    got_r.frame_bytes);
          check_field("duration_s",     exp_r.duration_s,     got_r.duration_s);
          check_field("header_ok",      exp_r.header_ok,      got_r.header_ok);
        end
      end
      if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_decodes.size());
        $display("** mpeg_audio_header_decode: FAILED **");
        $finish;
      end
    end
  end

  // corner headers: every version/layer, largest frames, longest duration,
  // each reserved or invalid code, all-zero and all-one fields
  task automatic test_directed();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_header(hdr_t'{VER_1,    LAYER_1,    4'd14,     FREQ_32K,  1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_2,    4'd14,     FREQ_32K,  1'b1, 32'h0000_0000});
    send_header(hdr_t'{VER_1,    LAYER_3,    4'd14,     FREQ_48K,  1'b0, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_3,    4'd1,      FREQ_44K,  1'b1, 32'h1234_5678});
    send_header(hdr_t'{VER_2,    LAYER_1,    4'd1,      FREQ_44K,  1'b0, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_2,    LAYER_2,    4'd1,      FREQ_48K,  1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_2,    LAYER_3,    4'd14,     FREQ_32K,  1'b1, 32'h0000_0000});
    send_header(hdr_t'{VER_2_5,  LAYER_1,    4'd14,     FREQ_32K,  1'b1, 32'h8000_0000});
    send_header(hdr_t'{VER_2_5,  LAYER_2,    4'd14,     FREQ_32K,  1'b1, 32'h7FFF_FFFF});
    send_header(hdr_t'{VER_2_5,  LAYER_3,    4'd1,      FREQ_32K,  1'b0, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_2_5,  LAYER_3,    4'd1,      FREQ_44K,  1'b0, 32'h0000_03E7});
    send_header(hdr_t'{VER_RSVD, LAYER_2,    4'd5,      FREQ_44K,  1'b0, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_RSVD, 4'd5,      FREQ_44K,  1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_2,    RATE_FREE, FREQ_44K,  1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_2,    RATE_BAD,  FREQ_48K,  1'b0, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_2,    LAYER_3,    4'd7,      FREQ_RSVD, 1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{2'd0,     2'd0,       4'd0,      2'd0,      1'b0, 32'h0000_0000});
    send_header(hdr_t'{2'd3,     2'd3,       4'd15,     2'd3,      1'b1, 32'hFFFF_FFFF});
    send_header(hdr_t'{VER_1,    LAYER_1,    4'd8,      FREQ_44K,  1'b0, 32'h0000_0001});
    send_header(hdr_t'{VER_2_5,  LAYER_2,    4'd9,      FREQ_48K,  1'b1, 32'h0000_0007});
    send_header(hdr_t'{VER_1,    LAYER_2,    4'd1,      FREQ_44K,  1'b0, 32'h0000_0F9F});
    send_header(hdr_t'{VER_1,    LAYER_2,    4'd1,      FREQ_44K,  1'b0, 32'h0000_0FA0});
  endtask

  task automatic test_no_idle();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_random(330);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct   = 75;
    ready_stall_pct = 0;
    send_random(330);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct   = 0;
    ready_stall_pct = 75;
    send_random(330);
  endtask

  task automatic test_both_idle();
    send_idle_pct   = 21;
    ready_stall_pct = 21;
    send_random(300);
  endtask

  // sender holds off until the pipe is empty, then resumes
  task automatic test_pause_until_drained();
    send_idle_pct   = 0;
    ready_stall_pct = 50;
    send_random(20);
    wait_drained();
    send_random(20);
  endtask

  initial begin
    rst                 = 1'b1;
    hdr_ch.valid        = 1'b0;
    hdr_ch.version_code = '0;
    hdr_ch.layer_code   = '0;
    hdr_ch.rate_index   = '0;
    hdr_ch.freq_index   = '0;
    hdr_ch.pad_slot     = 1'b0;
    hdr_ch.file_bytes   = '0;
    res_ch.ready        = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_no_idle();
    test_sender_gaps();
    test_pause_until_drained();
    test_receiver_stall();
    test_both_idle();

    wait_drained();
    repeat (PIPE_LATENCY + 6) @(negedge clk);
    if (mismatch_count == 0 && pending_decodes.size() == 0)
      $display("** mpeg_audio_header_decode: PASSED **");
    else
      $display("** mpeg_audio_header_decode: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mahd_pkg.sv
hw/rtl/mahd_if.sv
hw/rtl/mahd_front.sv
hw/rtl/mahd_cell.sv
hw/rtl/mahd_out.sv
hw/rtl/mpeg_audio_header_decode.sv
hw/rtl/mahd_checker.sv
tb/tb_mpeg_audio_header_decode.sv
